// ===== sv/pan_tilt_trigger_servo_controller_core_defines.svh =====
// Assertion macros shared by the servo controller RTL.
`ifndef PAN_TILT_TRIGGER_SERVO_CONTROLLER_CORE_DEFINES_SVH
`define PAN_TILT_TRIGGER_SERVO_CONTROLLER_CORE_DEFINES_SVH
`ifndef SYNTH
// Checks a property on every rising clock edge outside of reset.
`define PTTSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checks that a condition in one cycle implies another in the next cycle.
`define PTTSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PTTSC_ASSERT(lbl, prop, msg)
`define PTTSC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/pttsc_pkg.sv =====
// Types and constants of the pan/tilt/trigger servo controller.
package pttsc_pkg;

  localparam int unsigned PanW   = 14;
  localparam int unsigned StickW = 14;
  localparam int unsigned PulseW = 11;
  localparam int unsigned StepW  = 10;
  localparam int unsigned BandW  = 13;
  localparam int unsigned HoldW  = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 14;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_LINK   = 2'd1,
    CMD_TICK   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    MOT_STOP = 2'd0,
    MOT_UP   = 2'd1,
    MOT_DOWN = 2'd2
  } motion_e;

  typedef enum logic [1:0] {
    SEQ_IDLE = 2'd0,
    SEQ_MOVE = 2'd1,
    SEQ_TRIG = 2'd2
  } seq_e;

  localparam logic [7:0] LINK_RIGHT = 8'd0;
  localparam logic [7:0] LINK_LEFT  = 8'd1;
  localparam logic [7:0] LINK_DOWN  = 8'd2;
  localparam logic [7:0] LINK_UP    = 8'd3;
  localparam logic [7:0] LINK_FIRE  = 8'd4;

  localparam logic [CfgIdxW-1:0] CFG_PAN_MIN        = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PAN_MAX        = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_STICK_STEP     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_LINK_STEP      = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_STICK_CENTER   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_STICK_DEADBAND = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_TRIGGER_TICKS  = 3'd6;

  localparam logic [PulseW-1:0] PULSE_DOWN = 11'd1000;
  localparam logic [PulseW-1:0] PULSE_STOP = 11'd1150;
  localparam logic [PulseW-1:0] PULSE_UP   = 11'd1200;
  localparam logic [PanW-1:0]   PAN_RESET  = 14'd1100;
  localparam logic [PanW-1:0]   PAN_TOP    = 14'd16383;

  localparam logic [PanW-1:0]   PAN_MIN_RESET        = 14'd450;
  localparam logic [PanW-1:0]   PAN_MAX_RESET        = 14'd1800;
  localparam logic [StepW-1:0]  STICK_STEP_RESET     = 10'd100;
  localparam logic [StepW-1:0]  LINK_STEP_RESET      = 10'd20;
  localparam logic [StickW-1:0] STICK_CENTER_RESET   = 14'd8192;
  localparam logic [BandW-1:0]  STICK_DEADBAND_RESET = 13'd2500;
  localparam logic [HoldW-1:0]  TRIGGER_TICKS_RESET  = 4'd10;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [StickW-1:0] stick_x;
    logic [StickW-1:0] stick_y;
    logic              fire_pressed;
    logic              manual_pressed;
    logic [7:0]        link_byte;
  } pttsc_in_t;

  typedef struct packed {
    logic [PanW-1:0]   pan_pulse;
    logic [PulseW-1:0] tilt_pulse;
    logic [PulseW-1:0] trigger_pulse;
    logic              manual_mode;
    logic              trigger_busy;
  } pttsc_out_t;

  typedef struct packed {
    logic [PanW-1:0]   pan_min;
    logic [PanW-1:0]   pan_max;
    logic [StepW-1:0]  stick_step;
    logic [StepW-1:0]  link_step;
    logic [StickW-1:0] stick_center;
    logic [BandW-1:0]  stick_deadband;
    logic [HoldW-1:0]  trigger_ticks;
  } pttsc_cfg_t;

  typedef struct packed {
    logic [PanW-1:0]  pan;
    motion_e          tilt;
    motion_e          trig;
    seq_e             seq;
    logic [HoldW-1:0] hold;
    logic             manual;
  } pttsc_state_t;

  function automatic logic [PulseW-1:0] motion_pulse(motion_e m);
    logic [PulseW-1:0] p;
    unique case (m)
      MOT_UP:   p = PULSE_UP;
      MOT_DOWN: p = PULSE_DOWN;
      default:  p = PULSE_STOP;
    endcase
    return p;
  endfunction

endpackage

// ===== sv/pttsc_cfg.sv =====
// Configuration register file of the servo controller.
module pttsc_cfg
  import pttsc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output pttsc_cfg_t          cfg_o
);

  pttsc_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PAN_MIN:        cfg_d.pan_min        = cfg_wdata_i[PanW-1:0];
        CFG_PAN_MAX:        cfg_d.pan_max        = cfg_wdata_i[PanW-1:0];
        CFG_STICK_STEP:     cfg_d.stick_step     = cfg_wdata_i[StepW-1:0];
        CFG_LINK_STEP:      cfg_d.link_step      = cfg_wdata_i[StepW-1:0];
        CFG_STICK_CENTER:   cfg_d.stick_center   = cfg_wdata_i[StickW-1:0];
        CFG_STICK_DEADBAND: cfg_d.stick_deadband = cfg_wdata_i[BandW-1:0];
        CFG_TRIGGER_TICKS:  cfg_d.trigger_ticks  = cfg_wdata_i[HoldW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pan_min        <= PAN_MIN_RESET;
      cfg_q.pan_max        <= PAN_MAX_RESET;
      cfg_q.stick_step     <= STICK_STEP_RESET;
      cfg_q.link_step      <= LINK_STEP_RESET;
      cfg_q.stick_center   <= STICK_CENTER_RESET;
      cfg_q.stick_deadband <= STICK_DEADBAND_RESET;
      cfg_q.trigger_ticks  <= TRIGGER_TICKS_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/pttsc_update.sv =====
// Next-state and result logic for one item of the servo controller.
module pttsc_update
  import pttsc_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 14
) (
  input  pttsc_in_t    item_i,
  input  pttsc_cfg_t   cfg_i,
  input  pttsc_state_t st_i,
  output pttsc_state_t st_o,
  output pttsc_out_t   res_o
);

  // Readings wider than the field keep all of its bits.
  localparam int unsigned KeepBits = (SAMPLE_BITS < StickW) ? SAMPLE_BITS : StickW;
  localparam logic [StickW-1:0] SampleMask = StickW'((64'd1 << KeepBits) - 64'd1);

  logic [StickW-1:0] x, y;
  logic [StickW:0]   band_hi;
  logic              x_hi, x_lo, y_hi, y_lo;
  logic              pan_inc, pan_dec;
  logic [StepW-1:0]  step;
  logic [PanW:0]     pan_sum;
  pttsc_state_t      st;

  assign x = item_i.stick_x & SampleMask;
  assign y = item_i.stick_y & SampleMask;
  assign band_hi = {1'b0, cfg_i.stick_center} + {2'b0, cfg_i.stick_deadband};

  // The low side is compared as reading plus band against center, so a band
  // reaching below zero simply never fires.
  assign x_hi = {1'b0, x} > band_hi;
  assign y_hi = {1'b0, y} > band_hi;
  assign x_lo = ({1'b0, x} + {2'b0, cfg_i.stick_deadband}) < {1'b0, cfg_i.stick_center};
  assign y_lo = ({1'b0, y} + {2'b0, cfg_i.stick_deadband}) < {1'b0, cfg_i.stick_center};

  assign pan_sum = {1'b0, st_i.pan} + {5'b0, step};

  always_comb begin
    st      = st_i;
    pan_inc = 1'b0;
    pan_dec = 1'b0;
    step    = cfg_i.stick_step;
    unique case (item_i.cmd)
      CMD_SAMPLE: begin
        if (item_i.manual_pressed) st.manual = 1'b1;
        if (st.manual) begin
          pan_dec = x_hi;
          pan_inc = x_lo;
          if (y_hi) begin
            st.tilt = MOT_UP;
          end else if (y_lo) begin
            st.tilt = MOT_DOWN;
            st.seq  = SEQ_MOVE;
          end else begin
            st.tilt = MOT_STOP;
          end
          if (item_i.fire_pressed && st_i.trig == MOT_STOP) begin
            st.seq  = SEQ_TRIG;
            st.trig = MOT_DOWN;
            st.hold = 4'd1;
          end
        end
      end
      CMD_LINK: begin
        step = cfg_i.link_step;
        if (!st_i.manual) begin
          st.tilt = MOT_STOP;
          unique case (item_i.link_byte)
            LINK_RIGHT: pan_inc = 1'b1;
            LINK_LEFT:  pan_dec = 1'b1;
            LINK_DOWN, LINK_UP: begin
              if (st_i.seq != SEQ_TRIG) begin
                st.tilt = (item_i.link_byte == LINK_UP) ? MOT_UP : MOT_DOWN;
                st.seq  = SEQ_MOVE;
              end
            end
            LINK_FIRE: begin
              if (st_i.seq != SEQ_TRIG) begin
                st.seq  = SEQ_TRIG;
                st.trig = MOT_DOWN;
                st.hold = 4'd1;
              end
            end
            default: ;
          endcase
        end
      end
      CMD_TICK: begin
        if (st_i.seq == SEQ_TRIG) begin
          priority if (st_i.hold == cfg_i.trigger_ticks) begin
            st.trig = MOT_UP;
            st.hold = st_i.hold - 4'd1;
          end else if (st_i.hold == '0) begin
            st.trig = MOT_STOP;
            st.seq  = SEQ_IDLE;
          end else if (st_i.trig == MOT_DOWN) begin
            st.hold = st_i.hold + 4'd1;
          end else begin
            st.hold = st_i.hold - 4'd1;
          end
        end else if (st_i.seq == SEQ_MOVE) begin
          st.tilt = MOT_STOP;
          st.seq  = SEQ_IDLE;
        end
      end
      default: ;
    endcase

    // One shared step unit: a decrease wins, as the high side is tested first.
    if (pan_dec) begin
      if (st_i.pan > cfg_i.pan_min) begin
        st.pan = (st_i.pan > {4'b0, step}) ? st_i.pan - {4'b0, step} : '0;
      end
    end else if (pan_inc) begin
      if (st_i.pan < cfg_i.pan_max) begin
        st.pan = (pan_sum > {1'b0, PAN_TOP}) ? PAN_TOP : pan_sum[PanW-1:0];
      end
    end
  end

  assign st_o = st;

  assign res_o.pan_pulse     = st.pan;
  assign res_o.tilt_pulse    = motion_pulse(st.tilt);
  assign res_o.trigger_pulse = motion_pulse(st.trig);
  assign res_o.manual_mode   = st.manual;
  assign res_o.trigger_busy  = (st.seq == SEQ_TRIG);

endmodule

// ===== sv/pan_tilt_trigger_servo_controller_core.sv =====
// Top level of the pan/tilt/trigger servo controller.
//
// Each input transfer carries one item: a joystick sample, a link command
// byte or a timer tick, selected by the cmd field. Every item yields exactly
// one result transfer with the pan, tilt and trigger pulse widths and the
// manual-mode and trigger-busy status bits, taken after the item has acted.
// An accepted item sits in the input register, passes the update logic and
// lands in the result register once that register is free or drains, which
// then offers its result. One item is taken in every cycle while in_stall_o
// is low; the state registers are rewritten in the same cycle an item moves
// to the result register, so the next item already sees the new state.
// When the receiver stalls, the result register holds its transfer, the
// input register holds the next item, and in_stall_o rises only once both
// are full. Reset empties both registers and puts the servo state and the
// configuration registers at their defaults. The user must write the
// configuration through the plain write port only while no item is in
// flight; the block itself does not enforce this.
`include "pan_tilt_trigger_servo_controller_core_defines.svh"
module pan_tilt_trigger_servo_controller_core
  import pttsc_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 14
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pttsc_in_t           in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pttsc_out_t          out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  pttsc_cfg_t   cfg;
  pttsc_state_t state_q, state_d;
  pttsc_in_t    item_q;
  pttsc_out_t   res_d, res_q;
  logic         item_vld_q, out_vld_q;
  logic         adv, in_xfer;

  pttsc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pttsc_update #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_update (
    .item_i (item_q),
    .cfg_i  (cfg),
    .st_i   (state_q),
    .st_o   (state_d),
    .res_o  (res_d)
  );

  // The held item moves on whenever the result register is free or drains.
  assign adv        = item_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = item_vld_q && !adv;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (in_xfer) begin
        item_vld_q <= 1'b1;
      end else if (adv) begin
        item_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) item_q <= in_data_i;
    if (adv)     res_q  <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.pan    <= PAN_RESET;
      state_q.tilt   <= MOT_STOP;
      state_q.trig   <= MOT_STOP;
      state_q.seq    <= SEQ_IDLE;
      state_q.hold   <= '0;
      state_q.manual <= 1'b0;
    end else if (adv) begin
      state_q <= state_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = res_q;

  `PTTSC_ASSERT_NEXT(a_state_only_on_item, !adv, $stable(state_q),
                     "servo state changed without an item")
  `PTTSC_ASSERT_NEXT(a_result_follows_item, adv, out_valid_o,
                     "processed item produced no result")
  `PTTSC_ASSERT(a_manual_sticky, !$fell(state_q.manual),
                "manual mode was left")
  `PTTSC_ASSERT(a_trig_moves_in_seq, state_q.seq != SEQ_TRIG || state_q.trig != MOT_STOP,
                "trigger sequence running with trigger stopped")

endmodule
